// ===== rtl/gsplit_pkg.sv =====
// Shared types and constants for the granule even split block.
// No dependencies; imported by gsplit_alu and granule_even_split.
`timescale 1ns / 1ps

package gsplit_pkg;

    localparam int DATA_W          = 64;
    localparam int COUNT_W         = 7;
    localparam int INDEX_W         = 4;
    localparam int ALU_W           = DATA_W + 1;
    localparam int STEP_W          = $clog2(DATA_W);
    localparam int MAX_DOMAINS_DEF = 16;

    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic             carry;
        logic [ALU_W-1:0] sum;
    } alu_res_t;

endpackage

// ===== rtl/gsplit_alu.sv =====
// Shared 65-bit adder/subtractor used by every arithmetic step of the split.
// Depends on gsplit_pkg.
`timescale 1ns / 1ps

module gsplit_alu
    import gsplit_pkg::*;
(
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output alu_res_t         res
);

    logic [ALU_W:0] total;

    always_comb
    begin
        case (op)
            ALU_ADD:
            begin
                total = {1'b0, a} + {1'b0, b};
            end
            ALU_SUB:
            begin
                // carry set means a >= b
                total = {1'b0, a} + {1'b0, ~b} + {{ALU_W{1'b0}}, 1'b1};
            end
            default:
            begin
                total = '0;
            end
        endcase
        res.carry = total[ALU_W];
        res.sum   = total[ALU_W-1:0];
    end

endmodule

// ===== rtl/granule_even_split.sv =====
// Top level of the granule even split block: sequencer, datapath registers, output word.
// Depends on gsplit_pkg and gsplit_alu.
`timescale 1ns / 1ps

// A request word gives a total size, a domain count and a granule; the block splits the
// total into granule units spread evenly over the domains, the first (units mod domains)
// taking one unit more, and returns one word per domain with its byte size, the final one
// marked last. A bad request (a zero operand, too many domains, a total that is not a
// granule multiple, or fewer units than domains) returns a single error word. All work runs
// on one 65-bit adder/subtractor at one bit per cycle: a division for units = total/granule,
// a check, a division for units/domains, a shift-add for the base size and one add for the
// base size plus one granule; the result words then follow at one word per cycle while the
// sink takes them. A request rejected on its operands goes to the error state, one rejected
// after the first division to it through the check state; the error word is loaded once the
// output register is free. The request side is ready only between requests; the last result
// word may still be waiting when the next request is taken.

module granule_even_split
    import gsplit_pkg::*;
#(
    parameter int MAX_DOMAINS = MAX_DOMAINS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [DATA_W-1:0]   total_bytes,
    input  logic [COUNT_W-1:0]  domain_total,
    input  logic [DATA_W-1:0]   granule_bytes,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [INDEX_W-1:0]  domain_index,
    output logic [DATA_W-1:0]   domain_bytes,
    output logic                status,
    output logic                last
);

    localparam int IDX_W = $clog2(MAX_DOMAINS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV1 = 8'b0000_0010,
        ST_CHK  = 8'b0000_0100,
        ST_DIV2 = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_ADDG = 8'b0010_0000,
        ST_EMIT = 8'b0100_0000,
        ST_ERR  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                res_valid_reg, res_valid_next;

    logic [DATA_W-1:0]   gran_reg, gran_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   dvd_reg, dvd_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   plus_reg, plus_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [DATA_W-1:0]   out_bytes_reg, out_bytes_next;
    logic                out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    alu_op_t             alu_op;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    alu_res_t            alu_res;
    logic [DATA_W-1:0]   divisor;
    logic                bad_operands;
    logic                load_ok;
    logic                last_hit;

    gsplit_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign divisor      = (state_reg == ST_DIV2) ? DATA_W'(count_reg) : gran_reg;
    assign bad_operands = (total_bytes == '0) || (domain_total == '0) ||
                          (granule_bytes == '0) ||
                          (domain_total > COUNT_W'(MAX_DOMAINS));
    assign load_ok      = !res_valid_reg || res_ready;
    assign last_hit     = (IDX_W'(idx_reg + IDX_W'(1)) == count_reg);

    // operand selection for the shared unit
    always_comb
    begin
        case (state_reg)
            ST_DIV1, ST_DIV2:
            begin
                alu_op = ALU_SUB;
                alu_a  = {rem_reg, dvd_reg[DATA_W-1]};
                alu_b  = {1'b0, divisor};
            end
            ST_CHK:
            begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, dvd_reg};
                alu_b  = ALU_W'(count_reg);
            end
            ST_MUL:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, acc_reg[DATA_W-2:0], 1'b0};
                alu_b  = {1'b0, dvd_reg[DATA_W-1] ? gran_reg : {DATA_W{1'b0}}};
            end
            ST_ADDG:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, acc_reg};
                alu_b  = {1'b0, gran_reg};
            end
            default:
            begin
                alu_op = ALU_ADD;
                alu_a  = '0;
                alu_b  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        gran_next       = gran_reg;
        count_next      = count_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        plus_next       = plus_reg;
        out_index_next  = out_index_reg;
        out_bytes_next  = out_bytes_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    gran_next  = granule_bytes;
                    count_next = IDX_W'(domain_total);
                    dvd_next   = total_bytes;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = bad_operands ? ST_ERR : ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = alu_res.carry ? alu_res.sum[DATA_W-1:0] : alu_a[DATA_W-1:0];
                dvd_next  = {dvd_reg[DATA_W-2:0], alu_res.carry};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    if (state_reg == ST_DIV1)
                    begin
                        state_next = ST_CHK;
                    end
                    else
                    begin
                        acc_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_CHK:
            begin
                if ((rem_reg != '0) || !alu_res.carry)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV2;
                end
            end
            ST_MUL:
            begin
                // base share times granule, MSB first
                acc_next  = alu_res.sum[DATA_W-1:0];
                dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_ADDG;
                end
            end
            ST_ADDG:
            begin
                plus_next  = alu_res.sum[DATA_W-1:0];
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    res_valid_next  = 1'b1;
                    out_index_next  = INDEX_W'(idx_reg);
                    out_bytes_next  = (idx_reg < rem_reg[IDX_W-1:0]) ? plus_reg : acc_reg;
                    out_status_next = 1'b0;
                    out_last_next   = last_hit;
                    idx_next        = IDX_W'(idx_reg + IDX_W'(1));
                    if (last_hit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (load_ok)
                begin
                    res_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_bytes_next  = '0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gran_reg       <= gran_next;
        count_reg      <= count_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        plus_reg       <= plus_next;
        out_index_reg  <= out_index_next;
        out_bytes_reg  <= out_bytes_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign req_ready    = (state_reg == ST_IDLE);
    assign res_valid    = res_valid_reg;
    assign domain_index = out_index_reg;
    assign domain_bytes = out_bytes_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

    // error word is a single, empty, final word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status) |-> (last && (domain_bytes == '0) && (domain_index == '0)))
        else $error("error word malformed");

    // emit index stays inside the domain count
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg < count_reg))
        else $error("emit index past domain count");

    // an accepted request keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request side ready straight after accept");

endmodule
